[hdl/wlf_pkg.sv]
`timescale 1ns / 1ps

package wlf_pkg;

	localparam int COUNT_BITS = 16;

	localparam logic [31:0] UNIT_SIGMA = 32'h0001_0000;
	localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MINP = 64'h8000_0000_0000_0001;
	localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_ERR = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// add a signed term to a sum, clamp to +-(2^63 - 1)
	function automatic logic [63:0] acc_add(input logic [63:0] acc, input logic [127:0] term);
		logic [127:0] s;
		s = {{64{acc[63]}}, acc} + term;
		if (!s[127])
			return (s[127:64] == 64'd0 && !s[63]) ? s[63:0] : MAXP;
		return (s[127:64] == ALL1 && s[63:0] >= MINP) ? s[63:0] : MINP;
	endfunction

	function automatic logic [127:0] sadd128(input logic [127:0] a, input logic [127:0] b);
		logic [127:0] s;
		s = a + b;
		if (a[127] == b[127] && s[127] != a[127])
			return a[127] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
		return s;
	endfunction

	function automatic logic at_edge(input logic [63:0] v);
		return (v == MAXP) || (v == MINP);
	endfunction

endpackage

[hdl/weighted_line_fit_core.sv]
`timescale 1ns / 1ps

// Weighted straight-line fit y = a + b*x over a stream of points.
// Input channel (in_valid/in_ready): x_value, y_value (Q16.16), sigma_y
// (unsigned Q16.16) and last_point. Each point with nonzero sigma adds
// weight 1/sigma^2 into six running sums. The item marked last_point
// closes the set: one result follows on the output channel
// (out_valid/out_ready) with intercept, slope, their errors, chi_square
// (Q32.32) and fit_status; the sums then clear. in_ready is high only
// while the sequencer is idle. A point with nonzero sigma keeps in_ready
// low after it is taken while a 65-step divider forms the weight (skipped
// when the raw sigma is one) and nine products run, each as four 32x32
// passes through one shared multiplier. A zero-sigma point adds nothing.
// The closing point then runs up to five passes of the bit-serial divider
// (160 or 224 steps) and up to three 64-step square roots; without the
// unit-sigma scaling one of each drops out; an error result skips them.
// The result sits in an output register; while the receiver stalls the
// block still takes points, and a new result waits until the old one goes.
// Reset clears the sums, the count and the flags, and drops out_valid.
module weighted_line_fit_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  x_value,
	input  logic signed [31:0]  y_value,
	input  logic        [31:0]  sigma_y,
	input  logic                last_point,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  intercept,
	output logic signed [63:0]  slope,
	output logic        [63:0]  intercept_error,
	output logic        [63:0]  slope_error,
	output logic        [63:0]  chi_square,
	output logic        [1:0]   fit_status
);

	typedef enum logic [5:0] {
		S_IDLE, S_MUL, S_DIV, S_SQRT,
		P_W, P_WQ, P_S, P_SX, P_SY, P_XX0, P_XX, P_XY0, P_XY, P_YY0, P_YY,
		F_D0, F_D1, F_D2, F_CHK, F_A1, F_A2, F_A3, F_A4,
		F_B1, F_B2, F_B3, F_B4, F_EA1, F_EA2, F_EB1, F_EB2,
		F_C1, F_C2, F_C3, F_G1, F_G2, F_G3, F_G4, F_OUT
	} state_t;

	localparam int CB = wlf_pkg::COUNT_BITS;

	state_t state_q, ret_q;

	logic [31:0] mx_q, my_q;
	logic        xs_q, ys_q, last_q;
	logic [63:0] w_q;
	logic [CB-1:0] cnt_q;
	logic [63:0] s_w_q, s_x_q, s_y_q, s_xx_q, s_xy_q, s_yy_q;
	logic        unit_q, err_q;

	logic [63:0]  ma_q, mb_q;
	logic         mneg_q;
	logic [2:0]   mcnt_q;
	logic [63:0]  pp_s1;
	logic [127:0] prod_q;

	logic [127:0] dn_q, dd_q, dr_q, dq_q;
	logic         dovf_q;
	logic [7:0]   dcnt_q;

	logic [127:0] sv_q;
	logic [65:0]  srem_q;
	logic [63:0]  sroot_q;
	logic [5:0]   scnt_q;

	logic [127:0] tmp_q, del_q;
	logic         nneg_q, bad_q;
	logic [63:0]  a_q, b_q, ea_q, eb_q, chi_q;

	logic         out_valid_q;
	logic [63:0]  o_a_q, o_b_q, o_ea_q, o_eb_q, o_chi_q;
	logic [1:0]   o_st_q;

	// multiplier partial product
	logic [31:0]  ma_part, mb_part;
	logic [63:0]  pp;
	logic [127:0] pp_ext;

	always_comb begin
		case (mcnt_q)
			3'd0: begin
				ma_part = ma_q[31:0];
				mb_part = mb_q[31:0];
			end
			3'd1: begin
				ma_part = ma_q[31:0];
				mb_part = mb_q[63:32];
			end
			3'd2: begin
				ma_part = ma_q[63:32];
				mb_part = mb_q[31:0];
			end
			default: begin
				ma_part = ma_q[63:32];
				mb_part = mb_q[63:32];
			end
		endcase
		pp = ma_part * mb_part;
		case (mcnt_q)
			3'd1:    pp_ext = {64'd0, pp_s1};
			3'd2:    pp_ext = {32'd0, pp_s1, 32'd0};
			3'd3:    pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
	end

	// divider step
	logic [128:0] d_rem, d_diff;
	logic         d_ge;
	logic [127:0] d_next;

	always_comb begin
		d_rem  = {dr_q, dn_q[127]};
		d_diff = d_rem - {1'b0, dd_q};
		d_ge   = !d_diff[128];
		d_next = d_ge ? d_diff[127:0] : d_rem[127:0];
	end

	// square root step
	logic [67:0] s_rem, s_diff;
	logic        s_ge;

	always_comb begin
		s_rem  = {srem_q, sv_q[127:126]};
		s_diff = s_rem - {2'b00, sroot_q, 2'b01};
		s_ge   = !s_diff[67];
	end

	logic [127:0] prod_sr16, prod_sr32, div_res;
	logic [63:0]  q_mag, sres, fix_res;
	logic         sat;

	always_comb begin
		prod_sr16 = 128'($signed(prod_q) >>> 16);
		prod_sr32 = 128'($signed(prod_q) >>> 32);
		div_res   = dovf_q ? {128{1'b1}} : dq_q;
		q_mag     = (dovf_q || dq_q[127:63] != 65'd0) ? wlf_pkg::MAXP : dq_q[63:0];
		sres      = nneg_q ? (~q_mag + 64'd1) : q_mag;
		fix_res   = (prod_q[127:96] != 32'd0) ? wlf_pkg::ALL1 : prod_q[95:32];
		sat = wlf_pkg::at_edge(s_w_q) || wlf_pkg::at_edge(s_x_q) ||
			wlf_pkg::at_edge(s_y_q) || wlf_pkg::at_edge(s_xx_q) ||
			wlf_pkg::at_edge(s_xy_q) || wlf_pkg::at_edge(s_yy_q) ||
			wlf_pkg::at_edge(a_q) || wlf_pkg::at_edge(b_q) ||
			ea_q == wlf_pkg::ALL1 || eb_q == wlf_pkg::ALL1 || chi_q == wlf_pkg::ALL1;
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign intercept       = o_a_q;
	assign slope           = o_b_q;
	assign intercept_error = o_ea_q;
	assign slope_error     = o_eb_q;
	assign chi_square      = o_chi_q;
	assign fit_status      = o_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			s_w_q       <= '0;
			s_x_q       <= '0;
			s_y_q       <= '0;
			s_xx_q      <= '0;
			s_xy_q      <= '0;
			s_yy_q      <= '0;
			unit_q      <= 1'b1;
			err_q       <= 1'b0;
			mcnt_q      <= '0;
			dcnt_q      <= '0;
			scnt_q      <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cnt_q != {CB{1'b1}})
							cnt_q <= cnt_q + 1'b1;
						last_q <= last_point;
						xs_q   <= x_value[31];
						ys_q   <= y_value[31];
						mx_q   <= x_value[31] ? 32'(-x_value) : x_value;
						my_q   <= y_value[31] ? 32'(-y_value) : y_value;
						if (sigma_y == 32'd0) begin
							err_q   <= 1'b1;
							unit_q  <= 1'b0;
							state_q <= last_point ? F_D0 : S_IDLE;
						end else begin
							if (sigma_y != wlf_pkg::UNIT_SIGMA)
								unit_q <= 1'b0;
							ma_q    <= {32'd0, sigma_y};
							mb_q    <= {32'd0, sigma_y};
							mneg_q  <= 1'b0;
							mcnt_q  <= '0;
							prod_q  <= '0;
							ret_q   <= P_W;
							state_q <= S_MUL;
						end
					end
				end

				S_MUL: begin
					if (mcnt_q < 3'd4)
						pp_s1 <= pp;
					if (mcnt_q >= 3'd1 && mcnt_q <= 3'd4)
						prod_q <= prod_q + pp_ext;
					if (mcnt_q == 3'd5) begin
						prod_q  <= mneg_q ? (~prod_q + 128'd1) : prod_q;
						state_q <= ret_q;
					end
					mcnt_q <= mcnt_q + 3'd1;
				end

				S_DIV: begin
					dn_q <= {dn_q[126:0], 1'b0};
					dr_q <= d_next;
					dq_q <= {dq_q[126:0], d_ge};
					if (dq_q[127])
						dovf_q <= 1'b1;
					if (dcnt_q == 8'd0)
						state_q <= ret_q;
					else
						dcnt_q <= dcnt_q - 8'd1;
				end

				S_SQRT: begin
					sv_q <= {sv_q[125:0], 2'b00};
					if (s_ge) begin
						srem_q  <= s_diff[65:0];
						sroot_q <= {sroot_q[62:0], 1'b1};
					end else begin
						srem_q  <= s_rem[65:0];
						sroot_q <= {sroot_q[62:0], 1'b0};
					end
					if (scnt_q == 6'd0)
						state_q <= ret_q;
					else
						scnt_q <= scnt_q - 6'd1;
				end

				P_W: begin
					if (prod_q[63:0] == 64'd1) begin
						w_q     <= wlf_pkg::ALL1;
						state_q <= P_S;
					end else begin
						dn_q    <= {1'b1, 127'd0};
						dd_q    <= {64'd0, prod_q[63:0]};
						dr_q    <= '0;
						dq_q    <= '0;
						dovf_q  <= 1'b0;
						dcnt_q  <= 8'd64;
						ret_q   <= P_WQ;
						state_q <= S_DIV;
					end
				end

				P_WQ: begin
					w_q     <= dq_q[63:0];
					state_q <= P_S;
				end

				P_S: begin
					s_w_q   <= wlf_pkg::acc_add(s_w_q, {64'd0, w_q});
					ma_q    <= w_q;
					mb_q    <= {32'd0, mx_q};
					mneg_q  <= xs_q;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_SX;
					state_q <= S_MUL;
				end

				P_SX: begin
					s_x_q   <= wlf_pkg::acc_add(s_x_q, prod_sr16);
					ma_q    <= w_q;
					mb_q    <= {32'd0, my_q};
					mneg_q  <= ys_q;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_SY;
					state_q <= S_MUL;
				end

				P_SY: begin
					s_y_q   <= wlf_pkg::acc_add(s_y_q, prod_sr16);
					ma_q    <= {32'd0, mx_q};
					mb_q    <= {32'd0, mx_q};
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_XX0;
					state_q <= S_MUL;
				end

				P_XX0: begin
					ma_q    <= w_q;
					mb_q    <= prod_q[63:0];
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_XX;
					state_q <= S_MUL;
				end

				P_XX: begin
					s_xx_q  <= wlf_pkg::acc_add(s_xx_q, prod_q >> 32);
					ma_q    <= {32'd0, mx_q};
					mb_q    <= {32'd0, my_q};
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_XY0;
					state_q <= S_MUL;
				end

				P_XY0: begin
					ma_q    <= w_q;
					mb_q    <= prod_q[63:0];
					mneg_q  <= xs_q ^ ys_q;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_XY;
					state_q <= S_MUL;
				end

				P_XY: begin
					s_xy_q  <= wlf_pkg::acc_add(s_xy_q, prod_sr32);
					ma_q    <= {32'd0, my_q};
					mb_q    <= {32'd0, my_q};
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_YY0;
					state_q <= S_MUL;
				end

				P_YY0: begin
					ma_q    <= w_q;
					mb_q    <= prod_q[63:0];
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= P_YY;
					state_q <= S_MUL;
				end

				P_YY: begin
					s_yy_q  <= wlf_pkg::acc_add(s_yy_q, prod_q >> 32);
					state_q <= last_q ? F_D0 : S_IDLE;
				end

				// D = S*Sxx - Sx^2; second product comes back negated
				F_D0: begin
					ma_q    <= wlf_pkg::mag64(s_w_q);
					mb_q    <= wlf_pkg::mag64(s_xx_q);
					mneg_q  <= s_w_q[63] ^ s_xx_q[63];
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_D1;
					state_q <= S_MUL;
				end

				F_D1: begin
					tmp_q   <= prod_q;
					ma_q    <= wlf_pkg::mag64(s_x_q);
					mb_q    <= wlf_pkg::mag64(s_x_q);
					mneg_q  <= 1'b1;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_D2;
					state_q <= S_MUL;
				end

				F_D2: begin
					del_q   <= tmp_q + prod_q;
					state_q <= F_CHK;
				end

				F_CHK: begin
					if (err_q || del_q[127] || del_q == 128'd0) begin
						bad_q   <= 1'b1;
						state_q <= F_OUT;
					end else begin
						bad_q   <= 1'b0;
						ma_q    <= wlf_pkg::mag64(s_xx_q);
						mb_q    <= wlf_pkg::mag64(s_y_q);
						mneg_q  <= s_xx_q[63] ^ s_y_q[63];
						mcnt_q  <= '0;
						prod_q  <= '0;
						ret_q   <= F_A1;
						state_q <= S_MUL;
					end
				end

				F_A1: begin
					tmp_q   <= prod_q;
					ma_q    <= wlf_pkg::mag64(s_x_q);
					mb_q    <= wlf_pkg::mag64(s_xy_q);
					mneg_q  <= !(s_x_q[63] ^ s_xy_q[63]);
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_A2;
					state_q <= S_MUL;
				end

				F_A2: begin
					tmp_q   <= tmp_q + prod_q;
					state_q <= F_A3;
				end

				F_A3: begin
					nneg_q  <= tmp_q[127];
					dn_q    <= tmp_q[127] ? (~tmp_q + 128'd1) : tmp_q;
					dd_q    <= del_q;
					dr_q    <= '0;
					dq_q    <= '0;
					dovf_q  <= 1'b0;
					dcnt_q  <= 8'd159;
					ret_q   <= F_A4;
					state_q <= S_DIV;
				end

				F_A4: begin
					a_q     <= sres;
					ma_q    <= wlf_pkg::mag64(s_w_q);
					mb_q    <= wlf_pkg::mag64(s_xy_q);
					mneg_q  <= s_w_q[63] ^ s_xy_q[63];
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_B1;
					state_q <= S_MUL;
				end

				F_B1: begin
					tmp_q   <= prod_q;
					ma_q    <= wlf_pkg::mag64(s_x_q);
					mb_q    <= wlf_pkg::mag64(s_y_q);
					mneg_q  <= !(s_x_q[63] ^ s_y_q[63]);
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_B2;
					state_q <= S_MUL;
				end

				F_B2: begin
					tmp_q   <= tmp_q + prod_q;
					state_q <= F_B3;
				end

				F_B3: begin
					nneg_q  <= tmp_q[127];
					dn_q    <= tmp_q[127] ? (~tmp_q + 128'd1) : tmp_q;
					dd_q    <= del_q;
					dr_q    <= '0;
					dq_q    <= '0;
					dovf_q  <= 1'b0;
					dcnt_q  <= 8'd159;
					ret_q   <= F_B4;
					state_q <= S_DIV;
				end

				F_B4: begin
					b_q     <= sres;
					dn_q    <= {64'd0, s_xx_q};
					dd_q    <= del_q;
					dr_q    <= '0;
					dq_q    <= '0;
					dovf_q  <= 1'b0;
					dcnt_q  <= 8'd223;
					ret_q   <= F_EA1;
					state_q <= S_DIV;
				end

				F_EA1: begin
					sv_q    <= div_res;
					srem_q  <= '0;
					sroot_q <= '0;
					scnt_q  <= 6'd63;
					ret_q   <= F_EA2;
					state_q <= S_SQRT;
				end

				F_EA2: begin
					ea_q    <= sroot_q;
					dn_q    <= {64'd0, s_w_q};
					dd_q    <= del_q;
					dr_q    <= '0;
					dq_q    <= '0;
					dovf_q  <= 1'b0;
					dcnt_q  <= 8'd223;
					ret_q   <= F_EB1;
					state_q <= S_DIV;
				end

				F_EB1: begin
					sv_q    <= div_res;
					srem_q  <= '0;
					sroot_q <= '0;
					scnt_q  <= 6'd63;
					ret_q   <= F_EB2;
					state_q <= S_SQRT;
				end

				// chi2 = Syy - a*Sy - b*Sxy, products come back negated
				F_EB2: begin
					eb_q    <= sroot_q;
					ma_q    <= wlf_pkg::mag64(a_q);
					mb_q    <= wlf_pkg::mag64(s_y_q);
					mneg_q  <= !(a_q[63] ^ s_y_q[63]);
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_C1;
					state_q <= S_MUL;
				end

				F_C1: begin
					tmp_q   <= wlf_pkg::sadd128({{32{s_yy_q[63]}}, s_yy_q, 32'd0}, prod_q);
					ma_q    <= wlf_pkg::mag64(b_q);
					mb_q    <= wlf_pkg::mag64(s_xy_q);
					mneg_q  <= !(b_q[63] ^ s_xy_q[63]);
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_C2;
					state_q <= S_MUL;
				end

				F_C2: begin
					tmp_q   <= wlf_pkg::sadd128(tmp_q, prod_q);
					state_q <= F_C3;
				end

				F_C3: begin
					if (tmp_q[127])
						chi_q <= 64'd0;
					else
						chi_q <= (tmp_q[127:96] != 32'd0) ? wlf_pkg::ALL1 : tmp_q[95:32];
					if (unit_q && cnt_q != '0) begin
						dn_q    <= {64'd0,
							(tmp_q[127] ? 64'd0 :
							((tmp_q[127:96] != 32'd0) ? wlf_pkg::ALL1 : tmp_q[95:32]))};
						dd_q    <= {{(128 - CB){1'b0}}, cnt_q};
						dr_q    <= '0;
						dq_q    <= '0;
						dovf_q  <= 1'b0;
						dcnt_q  <= 8'd159;
						ret_q   <= F_G1;
						state_q <= S_DIV;
					end else begin
						state_q <= F_OUT;
					end
				end

				F_G1: begin
					sv_q    <= div_res;
					srem_q  <= '0;
					sroot_q <= '0;
					scnt_q  <= 6'd63;
					ret_q   <= F_G2;
					state_q <= S_SQRT;
				end

				F_G2: begin
					ma_q    <= ea_q;
					mb_q    <= sroot_q;
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_G3;
					state_q <= S_MUL;
				end

				F_G3: begin
					ea_q    <= fix_res;
					ma_q    <= eb_q;
					mb_q    <= sroot_q;
					mneg_q  <= 1'b0;
					mcnt_q  <= '0;
					prod_q  <= '0;
					ret_q   <= F_G4;
					state_q <= S_MUL;
				end

				F_G4: begin
					eb_q    <= fix_res;
					state_q <= F_OUT;
				end

				F_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						if (bad_q) begin
							o_a_q   <= '0;
							o_b_q   <= '0;
							o_ea_q  <= '0;
							o_eb_q  <= '0;
							o_chi_q <= '0;
							o_st_q  <= wlf_pkg::ST_ERR;
						end else begin
							o_a_q   <= a_q;
							o_b_q   <= b_q;
							o_ea_q  <= ea_q;
							o_eb_q  <= eb_q;
							o_chi_q <= chi_q;
							o_st_q  <= sat ? wlf_pkg::ST_SAT : wlf_pkg::ST_OK;
						end
						cnt_q   <= '0;
						s_w_q   <= '0;
						s_x_q   <= '0;
						s_y_q   <= '0;
						s_xx_q  <= '0;
						s_xy_q  <= '0;
						s_yy_q  <= '0;
						unit_q  <= 1'b1;
						err_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/wlf_checker.sv]
`timescale 1ns / 1ps

module wlf_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] intercept,
	input logic [63:0] slope,
	input logic [63:0] intercept_error,
	input logic [63:0] slope_error,
	input logic [63:0] chi_square,
	input logic [1:0]  fit_status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(intercept) && $stable(slope)
			&& $stable(chi_square) && $stable(fit_status))
		else $error("result changed while stalled");

	// error result carries zeros
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fit_status == wlf_pkg::ST_ERR |-> intercept == 64'd0 && slope == 64'd0
			&& intercept_error == 64'd0 && slope_error == 64'd0 && chi_square == 64'd0)
		else $error("error item with nonzero fields");

	// ok status means nothing sits at a saturation edge
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fit_status == wlf_pkg::ST_OK |-> !wlf_pkg::at_edge(intercept)
			&& !wlf_pkg::at_edge(slope) && intercept_error != wlf_pkg::ALL1
			&& slope_error != wlf_pkg::ALL1 && chi_square != wlf_pkg::ALL1)
		else $error("ok status on saturated item");

endmodule

bind weighted_line_fit_core wlf_assertions u_wlf_assertions (.*);

[tb/sv/wlf_checker.sv]
`timescale 1ns / 1ps

module wlf_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic        [31:0] sigma_y,
	input  logic               last_point,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [63:0] intercept,
	input  logic signed [63:0] slope,
	input  logic        [63:0] intercept_error,
	input  logic        [63:0] slope_error,
	input  logic        [63:0] chi_square,
	input  logic        [1:0]  fit_status,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct {
		logic [63:0] icpt;
		logic [63:0] slp;
		logic [63:0] icpt_err;
		logic [63:0] slp_err;
		logic [63:0] chi;
		wlf_pkg::status_t status;
	} fit_t;

	fit_t fits_due[$];

	logic [wlf_pkg::COUNT_BITS-1:0] n_pts;
	logic [63:0] s_w, s_wx, s_wy, s_wxx, s_wxy, s_wyy;
	logic unit_only, bad_sigma;

	function automatic logic signed [127:0] sx(input logic [63:0] v);
		return $signed({{64{v[63]}}, v});
	endfunction

	function automatic logic [63:0] absval(input logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic logic [63:0] clamp_sum(input logic [63:0] acc,
			input logic signed [127:0] term);
		logic signed [127:0] s;
		s = sx(acc) + term;
		if (s > $signed({64'd0, wlf_pkg::MAXP}))
			return wlf_pkg::MAXP;
		if (s < -$signed({64'd0, wlf_pkg::MAXP}))
			return wlf_pkg::MINP;
		return s[63:0];
	endfunction

	function automatic logic signed [127:0] sat_add(input logic signed [127:0] a,
			input logic signed [127:0] b);
		logic signed [127:0] s;
		s = a + b;
		if (a[127] == b[127] && s[127] != a[127])
			return a[127] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
		return s;
	endfunction

	// floor(n * 2^sh / d), all ones when it does not fit
	function automatic logic [127:0] quot(input logic [127:0] n, input logic [127:0] d,
			input int sh);
		logic [255:0] q;
		q = ({128'd0, n} << sh) / {128'd0, d};
		return (q[255:128] != 0) ? {128{1'b1}} : q[127:0];
	endfunction

	function automatic logic [63:0] root(input logic [127:0] v);
		logic [63:0] r, t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] ratio(input logic signed [127:0] n,
			input logic [127:0] d);
		logic [127:0] q, m;
		q = quot(n[127] ? -n : n, d, 32);
		m = (q > {64'd0, wlf_pkg::MAXP}) ? {64'd0, wlf_pkg::MAXP} : q;
		return n[127] ? -m[63:0] : m[63:0];
	endfunction

	function automatic logic [63:0] scale(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> 32;
		return (p[127:64] != 0) ? wlf_pkg::ALL1 : p[63:0];
	endfunction

	task automatic clear_sums();
		n_pts = 0;
		s_w = 0; s_wx = 0; s_wy = 0; s_wxx = 0; s_wxy = 0; s_wyy = 0;
		unit_only = 1'b1;
		bad_sigma = 1'b0;
	endtask

	task automatic fold_point(input logic [31:0] xv, input logic [31:0] yv,
			input logic [31:0] sv, input logic last);
		logic [63:0] r2, w, mx, my, xy, xe, ye;
		logic signed [127:0] p, det, num_a, num_b, resid;
		logic [127:0] tt;
		fit_t f;
		if (n_pts != {wlf_pkg::COUNT_BITS{1'b1}})
			n_pts++;
		if (sv == 0) begin
			bad_sigma = 1'b1;
			unit_only = 1'b0;
		end else begin
			if (sv != wlf_pkg::UNIT_SIGMA)
				unit_only = 1'b0;
			r2 = {32'd0, sv} * {32'd0, sv};
			w = (r2 == 1) ? wlf_pkg::ALL1 : 64'((128'd1 << 64) / {64'd0, r2});
			xe = {{32{xv[31]}}, xv};
			ye = {{32{yv[31]}}, yv};
			mx = absval(xe);
			my = absval(ye);
			xy = mx * my;
			if (xv[31] ^ yv[31])
				xy = -xy;
			s_w = clamp_sum(s_w, $signed({64'd0, w}));
			p = $signed({64'd0, w}) * sx(xe);
			s_wx = clamp_sum(s_wx, p >>> 16);
			p = $signed({64'd0, w}) * sx(ye);
			s_wy = clamp_sum(s_wy, p >>> 16);
			s_wxx = clamp_sum(s_wxx, $signed(({64'd0, w} * {64'd0, mx * mx}) >> 32));
			p = $signed({64'd0, w}) * sx(xy);
			s_wxy = clamp_sum(s_wxy, p >>> 32);
			s_wyy = clamp_sum(s_wyy, $signed(({64'd0, w} * {64'd0, my * my}) >> 32));
		end
		if (!last)
			return;
		f = '{0, 0, 0, 0, 0, wlf_pkg::ST_ERR};
		det = sx(s_w) * sx(s_wxx) - sx(s_wx) * sx(s_wx);
		if (!bad_sigma && det > 0) begin
			num_a = sx(s_wxx) * sx(s_wy) - sx(s_wx) * sx(s_wxy);
			num_b = sx(s_w) * sx(s_wxy) - sx(s_wx) * sx(s_wy);
			f.icpt = ratio(num_a, det);
			f.slp = ratio(num_b, det);
			f.icpt_err = root(quot({64'd0, s_wxx}, det, 96));
			f.slp_err = root(quot({64'd0, s_w}, det, 96));
			resid = sat_add(sx(s_wyy) <<< 32, -(sx(f.icpt) * sx(s_wy)));
			resid = sat_add(resid, -(sx(f.slp) * sx(s_wxy)));
			if (!resid[127]) begin
				tt = resid >> 32;
				f.chi = (tt[127:64] != 0) ? wlf_pkg::ALL1 : tt[63:0];
			end
			if (unit_only && n_pts != 0) begin
				mx = root(quot({64'd0, f.chi},
					{{(128-wlf_pkg::COUNT_BITS){1'b0}}, n_pts}, 32));
				f.icpt_err = scale(f.icpt_err, mx);
				f.slp_err = scale(f.slp_err, mx);
			end
			f.status = wlf_pkg::ST_OK;
			if (wlf_pkg::at_edge(s_w) || wlf_pkg::at_edge(s_wx) || wlf_pkg::at_edge(s_wy)
					|| wlf_pkg::at_edge(s_wxx) || wlf_pkg::at_edge(s_wxy)
					|| wlf_pkg::at_edge(s_wyy) || wlf_pkg::at_edge(f.icpt)
					|| wlf_pkg::at_edge(f.slp) || f.icpt_err == wlf_pkg::ALL1
					|| f.slp_err == wlf_pkg::ALL1 || f.chi == wlf_pkg::ALL1)
				f.status = wlf_pkg::ST_SAT;
		end
		fits_due.push_back(f);
		clear_sums();
	endtask

	always @(posedge clk or negedge arst_n) begin
		fit_t e;
		if (!arst_n) begin
			clear_sums();
			fits_due.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (fits_due.size() == 0) begin
					$error("result with no fit pending");
					mismatches <= mismatches + 1;
				end else begin
					e = fits_due.pop_front();
					if (intercept !== e.icpt || slope !== e.slp
							|| intercept_error !== e.icpt_err
							|| slope_error !== e.slp_err || chi_square !== e.chi
							|| fit_status !== e.status)
						mismatches <= mismatches + 1;
					if (intercept !== e.icpt)
						$error("intercept: expected %h, got %h", e.icpt, intercept);
					if (slope !== e.slp)
						$error("slope: expected %h, got %h", e.slp, slope);
					if (intercept_error !== e.icpt_err)
						$error("intercept_error: expected %h, got %h", e.icpt_err,
							intercept_error);
					if (slope_error !== e.slp_err)
						$error("slope_error: expected %h, got %h", e.slp_err, slope_error);
					if (chi_square !== e.chi)
						$error("chi_square: expected %h, got %h", e.chi, chi_square);
					if (fit_status !== e.status)
						$error("fit_status: expected %0d, got %0d", e.status, fit_status);
				end
			end
			if (in_valid && in_ready)
				fold_point(x_value, y_value, sigma_y, last_point);
			outstanding <= fits_due.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int N_ITEMS = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] x_value = '0;
	logic signed [31:0] y_value = '0;
	logic [31:0] sigma_y = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] intercept, slope;
	logic [63:0] intercept_error, slope_error, chi_square;
	logic [1:0] fit_status;
	int mismatches, outstanding;
	int cycles = 0;
	int points_sent = 0;
	int burst_left = 0;
	int stall_left = 0;

	always #6 clk = ~clk;

	weighted_line_fit_core dut (.*);

	wlf_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("weighted_line_fit_core: mismatch");
			$finish;
		end
	end

	// receiver: calm stretches, then stretches with stalls of random length
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ((cycles / 4000) % 3 != 0 && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 60);
		end
	end

	task automatic send_point(input logic [31:0] xv, input logic [31:0] yv,
			input logic [31:0] sv, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		x_value <= xv;
		y_value <= yv;
		sigma_y <= sv;
		last_point <= last;
		do @(posedge clk); while (!in_ready);
		points_sent++;
	endtask

	function automatic logic [31:0] rand_coord();
		int k;
		logic [31:0] v;
		if ($urandom_range(0, 15) == 0)
			return $urandom();
		k = $urandom_range(4, 30);
		v = $urandom() & ((32'd1 << k) - 1);
		return v[k-1] ? (v | ~((32'd1 << k) - 1)) : v;
	endfunction

	task automatic random_set();
		int n, kind;
		logic [31:0] xv, sv, base, step;
		n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
		kind = $urandom_range(0, 9);
		base = rand_coord();
		step = $urandom_range(1, 32'h0004_0000);
		for (int i = 0; i < n; i++) begin
			case (kind)
				0, 1, 2, 3: sv = wlf_pkg::UNIT_SIGMA;
				4: sv = $urandom();
				default: sv = $urandom_range(32'h0000_2000, 32'h0010_0000);
			endcase
			if ($urandom_range(0, 49) == 0)
				sv = 0;
			else if ($urandom_range(0, 99) == 0)
				sv = 1;
			xv = (kind == 9) ? base : (($urandom_range(0, 4) == 0) ? rand_coord()
				: base + i * step);
			send_point(xv, rand_coord(), sv, i == n - 1);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// single point: no spread
		send_point(32'h0001_0000, 32'h0002_0000, wlf_pkg::UNIT_SIGMA, 1'b1);
		// unit sigma line, errors scaled by the residual
		send_point(32'h0000_0000, 32'h0001_0000, wlf_pkg::UNIT_SIGMA, 1'b0);
		send_point(32'h0001_0000, 32'h0003_1000, wlf_pkg::UNIT_SIGMA, 1'b0);
		send_point(32'h0002_0000, 32'h0004_F000, wlf_pkg::UNIT_SIGMA, 1'b0);
		send_point(32'h0003_0000, 32'h0007_0800, wlf_pkg::UNIT_SIGMA, 1'b1);
		// a zero sigma spoils the set
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 1'b0);
		send_point(32'h0002_0000, 32'h0005_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0003_0000, 32'h0002_0000, 32'h0002_0000, 1'b1);
		// identical abscissae
		send_point(32'h0004_0000, 32'h0001_0000, 32'h0001_8000, 1'b0);
		send_point(32'h0004_0000, 32'hFFFF_0000, 32'h0000_C000, 1'b1);
		// raw sigma of one saturates the weight sum
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 1'b1);
		// field extremes with the largest sigma
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// extremes with small sigma drive the sums to their limits
		send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0100, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0100, 1'b0);
		send_point(32'h0000_0001, 32'h8000_0000, 32'h0000_0100, 1'b1);
		// steep slope with tiny spread
		send_point(32'h0000_0000, 32'h8000_0000, 32'h0001_0000, 1'b0);
		send_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1);
		while (points_sent < N_ITEMS + 20)
			random_set();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2500) @(posedge clk);
		if (mismatches == 0)
			$display("weighted_line_fit_core: match");
		else
			$display("weighted_line_fit_core: mismatch");
		$finish;
	end

endmodule
